[rtl/core/irs_pkg.sv]
// package for the integer range set block
// commands, sequencer states and default sizes; no dependencies
`default_nettype none
package irs_pkg;
  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned ValueBitsDef = 31;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_SUM,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

[rtl/core/integer_range_set_top.sv]
// integer range set: sorted table of disjoint inclusive ranges; uses irs_pkg
// an item passes through the states scan, copy back, sum and done, in that order;
// an item dropped on overflow skips the copy back; a new item is taken only in idle,
// once the last one is done; busy is high while an item is at work
// result is shown for one cycle on done_o; the receiver cannot stall
// reset clears the range count; the table contents need no clearing
`default_nettype none
module integer_range_set_top #(
  parameter int unsigned MAX_RANGES = irs_pkg::MaxRangesDef,
  parameter int unsigned VALUE_BITS = irs_pkg::ValueBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic [VALUE_BITS-1:0]             value_i,
  input  wire logic [VALUE_BITS-1:0]             range_lo_i,
  input  wire logic [VALUE_BITS-1:0]             range_hi_i,
  output logic                                   done_o,
  output logic [$clog2(MAX_RANGES + 2)-1:0]      ranges_held_o,
  output logic [31:0]                            total_count_o,
  output logic [VALUE_BITS-1:0]                  min_value_o,
  output logic [VALUE_BITS-1:0]                  max_value_o,
  output logic                                   is_empty_o,
  output logic                                   overflow_o
);
  import irs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 2);
  localparam int unsigned VB = VALUE_BITS;

  // working copy: old table in st/en, rebuilt into new table in ns/ne
  logic [VB-1:0] st_q [MAX_RANGES];
  logic [VB-1:0] en_q [MAX_RANGES];
  logic [VB-1:0] ns_q [MAX_RANGES+1];
  logic [VB-1:0] ne_q [MAX_RANGES+1];

  state_e state_q, state_d;
  logic [CW-1:0] n_q, i_q, m_q;
  logic [1:0] cmd_q;
  logic [VB-1:0] v_q, lo_q, hi_q;
  logic ovf_q, merged_q, placed_q;
  logic [31:0] sum_q;

  assign busy = (state_q != ST_IDLE);

  logic [VB-1:0] cs, ce;
  assign cs = st_q[i_q[IW-1:0]];
  assign ce = en_q[i_q[IW-1:0]];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_SCAN;
      ST_SCAN:  if (i_q == n_q) state_d = ST_SHIFT;
      ST_SHIFT: if (i_q == m_q || ovf_q) state_d = ST_SUM;
      ST_SUM:   if (i_q == n_q) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // add is done as a general rebuild: emit ranges in order, joining with v
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q <= '0;
      i_q <= '0;
      m_q <= '0;
      done_o <= 1'b0;
      cmd_q <= '0;
      v_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      ovf_q <= 1'b0;
      merged_q <= 1'b0;
      placed_q <= 1'b0;
      sum_q <= '0;
    end else begin
      state_q <= state_d;
      done_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (start) begin
          cmd_q <= cmd_i;
          v_q <= value_i;
          lo_q <= range_lo_i;
          hi_q <= range_hi_i;
          i_q <= '0;
          m_q <= '0;
          placed_q <= 1'b0;
          merged_q <= 1'b0;
          ovf_q <= 1'b0;
        end
        ST_SCAN: begin
          if (i_q != n_q) begin
            i_q <= i_q + 1'b1;
            if (cmd_q == CMD_ADD) begin
              if (!placed_q && ({1'b0, v_q} + 1'b1 < {1'b0, cs})) begin
                // v goes before this range
                ns_q[m_q] <= v_q; ne_q[m_q] <= v_q;
                ns_q[m_q+1'b1] <= cs; ne_q[m_q+1'b1] <= ce;
                m_q <= m_q + 2'd2;
                placed_q <= 1'b1;
              end else if (!placed_q && ({1'b0, ce} + 1'b1 >= {1'b0, v_q})) begin
                // touches v: absorb
                ns_q[m_q] <= (v_q < cs) ? v_q : cs;
                ne_q[m_q] <= (v_q > ce) ? v_q : ce;
                m_q <= m_q + 1'b1;
                placed_q <= 1'b1;
                merged_q <= 1'b1;
              end else if (merged_q && m_q != 0 &&
                           ({1'b0, ne_q[m_q-1'b1]} + 1'b1 == {1'b0, cs})) begin
                ne_q[m_q-1'b1] <= ce;
                merged_q <= 1'b0;
              end else begin
                ns_q[m_q] <= cs; ne_q[m_q] <= ce;
                m_q <= m_q + 1'b1;
                merged_q <= 1'b0;
              end
            end else if (cmd_q == CMD_REMOVE && lo_q <= hi_q) begin
              if (ce < lo_q || cs > hi_q) begin
                ns_q[m_q] <= cs; ne_q[m_q] <= ce;
                m_q <= m_q + 1'b1;
              end else if (cs < lo_q && ce > hi_q) begin
                ns_q[m_q] <= cs; ne_q[m_q] <= lo_q - 1'b1;
                ns_q[m_q+1'b1] <= hi_q + 1'b1; ne_q[m_q+1'b1] <= ce;
                m_q <= m_q + 2'd2;
              end else if (cs < lo_q) begin
                ns_q[m_q] <= cs; ne_q[m_q] <= lo_q - 1'b1;
                m_q <= m_q + 1'b1;
              end else if (ce > hi_q) begin
                ns_q[m_q] <= hi_q + 1'b1; ne_q[m_q] <= ce;
                m_q <= m_q + 1'b1;
              end
            end else if (cmd_q == CMD_CLEAR) begin
              // nothing kept
            end else begin
              ns_q[m_q] <= cs; ne_q[m_q] <= ce;
              m_q <= m_q + 1'b1;
            end
          end else begin
            if (cmd_q == CMD_ADD && !placed_q) begin
              ns_q[m_q] <= v_q; ne_q[m_q] <= v_q;
              m_q <= m_q + 1'b1;
              if (m_q >= CW'(MAX_RANGES)) ovf_q <= 1'b1;
            end else if (m_q > CW'(MAX_RANGES)) begin
              ovf_q <= 1'b1;
            end
            i_q <= '0;
          end
        end
        ST_SHIFT: begin
          if (!ovf_q && i_q != m_q) begin
            st_q[i_q[IW-1:0]] <= ns_q[i_q];
            en_q[i_q[IW-1:0]] <= ne_q[i_q];
            i_q <= i_q + 1'b1;
          end
          if (i_q == m_q || ovf_q) begin
            if (!ovf_q) n_q <= m_q;
            i_q <= '0;
            sum_q <= '0;
          end
        end
        ST_SUM: begin
          if (i_q != n_q) begin
            sum_q <= sum_q + 32'({1'b0, ce} - {1'b0, cs} + 1'b1);
            i_q <= i_q + 1'b1;
          end
        end
        ST_DONE: done_o <= 1'b1;
        default: ;
      endcase
    end
  end

  assign ranges_held_o = n_q;
  assign total_count_o = sum_q;
  assign is_empty_o = (n_q == 0);
  assign min_value_o = (n_q == 0) ? '0 : st_q[0];
  assign max_value_o = (n_q == 0) ? '0 : en_q[IW'(n_q - 1'b1)];
  assign overflow_o = ovf_q;

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= CW'(MAX_RANGES))
    else $error("range count above table size");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("done while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(n_q))
    else $error("count changed during scan");
`endif
endmodule
`default_nettype wire
